// File: hw/rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Types, constants and step functions shared by the Fourier phase shifter.
// ----------------------------------------------------------------------------
package fps_pkg;

	typedef struct packed {
		logic [9:0]         row_index;
		logic [9:0]         col_index;
		logic signed [31:0] sample_real;
		logic signed [31:0] sample_imag;
	} fps_in_t;

	typedef struct packed {
		logic signed [31:0] shifted_real;
		logic signed [31:0] shifted_imag;
	} fps_out_t;

	typedef enum logic [1:0] {
		CFG_NUM_ROWS      = 2'd0,
		CFG_NUM_HALF_COLS = 2'd1,
		CFG_SHIFT_X       = 2'd2,
		CFG_SHIFT_Y       = 2'd3
	} cfg_reg_t;

	localparam int N_W          = 13;  // axis length, up to 1024 at the default limits
	localparam int K_W          = 14;  // signed frequency index
	localparam int D_W          = 14;  // divisor 2*n
	localparam int PROD_W       = 46;  // k * shift
	localparam int DIV_W        = 64;  // dividend magnitude
	localparam int Q_W          = 32;  // kept quotient bits
	localparam int DIV_PER      = 8;
	localparam int DIV_STAGES   = DIV_W / DIV_PER;
	localparam int CW           = 50;  // CORDIC x/y width, Q.16
	localparam int CORDIC_STEPS = 32;
	localparam int COR_PER      = 2;
	localparam int COR_STAGES   = CORDIC_STEPS / COR_PER;
	localparam logic [32:0] INV_GAIN = 33'd2608131496;

	typedef struct packed {
		logic [D_W-1:0]   rem;
		logic [DIV_W-1:0] u;
		logic [Q_W-1:0]   q;
	} div_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [31:0]   z;
	} cor_t;

	function automatic logic signed [31:0] atan_turn(input int i);
		logic signed [31:0] r;
		case (i)
			0:  r = 32'sd536870912;
			1:  r = 32'sd316933406;
			2:  r = 32'sd167458907;
			3:  r = 32'sd85004756;
			4:  r = 32'sd42667331;
			5:  r = 32'sd21354465;
			6:  r = 32'sd10679838;
			7:  r = 32'sd5340245;
			8:  r = 32'sd2670163;
			9:  r = 32'sd1335087;
			10: r = 32'sd667544;
			11: r = 32'sd333772;
			12: r = 32'sd166886;
			13: r = 32'sd83443;
			14: r = 32'sd41722;
			15: r = 32'sd20861;
			16: r = 32'sd10430;
			17: r = 32'sd5215;
			18: r = 32'sd2608;
			19: r = 32'sd1304;
			20: r = 32'sd652;
			21: r = 32'sd326;
			22: r = 32'sd163;
			23: r = 32'sd81;
			24: r = 32'sd41;
			25: r = 32'sd20;
			26: r = 32'sd10;
			27: r = 32'sd5;
			28: r = 32'sd3;
			29: r = 32'sd1;
			30: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// restoring long division, DIV_PER quotient bits
	function automatic div_t div_steps(input div_t a, input logic [D_W-1:0] d);
		div_t            r;
		logic [D_W:0]    t;
		r = a;
		for (int k = 0; k < DIV_PER; k++) begin
			t   = {r.rem, r.u[DIV_W-1]};
			r.u = {r.u[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t   = t - {1'b0, d};
				r.q = {r.q[Q_W-2:0], 1'b1};
			end else begin
				r.q = {r.q[Q_W-2:0], 1'b0};
			end
			r.rem = t[D_W-1:0];
		end
		return r;
	endfunction

	function automatic cor_t cor_iter(input cor_t a, input int i);
		cor_t                 r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		dx = a.y >>> i;
		dy = a.x >>> i;
		if (!a.z[31]) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - atan_turn(i);
		end else begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + atan_turn(i);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] round_sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0]    t;
		logic signed [CW-17:0]   r;
		t = v + CW'(32768);
		r = (CW-16)'(t >>> 16);
		if (r > (CW-16)'(64'sd2147483647))
			return 32'sh7FFFFFFF;
		if (r < -(CW-16)'(64'sd2147483648))
			return 32'sh80000000;
		return r[31:0];
	endfunction

endpackage

// File: hw/rtl/fourier_phase_shift.sv
// ----------------------------------------------------------------------------
// fourier_phase_shift
// Rotates half-complex 2-D spectrum coefficients by the Fourier shift phase.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_data (row, column, real, imag).
// Output channel: out_valid/out_stall with out_data (rotated real, imag).
// A transfer happens on a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_data to register cfg_index (rows, half
// columns, shift x, shift y); write only while no coefficient is in flight.
// Throughput: one coefficient per cycle while no held result stalls the output, fully pipelined.
// Pipeline from input transfer to out_valid: index map, multiply,
// dividend setup, 8 stages of an 8-bit-per-stage divider per axis, phase
// and quadrant fold, 16 stages of two CORDIC iterations, rounding register.
// The CORDIC rotation is what sets most of the depth.
// Reset: pipeline empties, registers load 256 rows, 129 half columns, zero
// shift. When out_stall holds a valid result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fourier_phase_shift
	import fps_pkg::*;
#(
	parameter int MAX_ROWS      = 1024,
	parameter int MAX_HALF_COLS = 513,
	parameter int PHASE_BITS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  fps_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output fps_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [63:0] PH_STEP = 64'd1 << (32 - PHASE_BITS);
	localparam logic [31:0] PH_HALF = 32'(PH_STEP >> 1);
	localparam logic [31:0] PH_MASK = 32'(~(PH_STEP - 64'd1));

	// configuration
	logic [10:0]        num_rows_q;
	logic [9:0]         num_half_cols_q;
	logic signed [31:0] shift_x_q;
	logic signed [31:0] shift_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q      <= 11'd256;
			num_half_cols_q <= 10'd129;
			shift_x_q       <= '0;
			shift_y_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_NUM_ROWS:      num_rows_q      <= cfg_data[10:0];
				CFG_NUM_HALF_COLS: num_half_cols_q <= cfg_data[9:0];
				CFG_SHIFT_X:       shift_x_q       <= cfg_data;
				CFG_SHIFT_Y:       shift_y_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [N_W-1:0] n_y, n_h, n_x;
	logic [D_W-1:0] d_y, d_x;

	always_comb begin
		n_y = ({2'b0, num_rows_q} > N_W'(MAX_ROWS)) ? N_W'(MAX_ROWS) : {2'b0, num_rows_q};
		n_h = ({3'b0, num_half_cols_q} > N_W'(MAX_HALF_COLS)) ?
			N_W'(MAX_HALF_COLS) : {3'b0, num_half_cols_q};
		n_x = (n_h >= N_W'(2)) ? N_W'((n_h - N_W'(1)) << 1) : '0;
		d_y = {n_y, 1'b0};
		d_x = {n_x, 1'b0};
	end

	// whole pipeline advances unless a finished result is held
	logic ce;
	assign ce       = !out_valid || !out_stall;
	assign in_stall = !ce;

	// ---- stage 1: index to signed frequency index
	logic                  v_s1;
	logic signed [K_W-1:0] ky_s1, kx_s1;
	logic signed [31:0]    re_s1, im_s1;
	logic signed [K_W-1:0] ky_c, kx_c;

	always_comb begin
		if ({4'b0, in_data.row_index} <= {2'b0, n_y >> 1})
			ky_c = $signed({4'b0, in_data.row_index});
		else
			ky_c = $signed({4'b0, in_data.row_index} - {1'b0, n_y});
		if ({4'b0, in_data.col_index} <= {2'b0, n_x >> 1})
			kx_c = $signed({4'b0, in_data.col_index});
		else
			kx_c = $signed({4'b0, in_data.col_index} - {1'b0, n_x});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (ce)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ky_s1 <= ky_c;
			kx_s1 <= kx_c;
			re_s1 <= in_data.sample_real;
			im_s1 <= in_data.sample_imag;
		end
	end

	// ---- stage 2: products
	logic                     v_s2;
	logic signed [PROD_W-1:0] py_s2, px_s2;
	logic signed [63:0]       xg_s2, yg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (ce)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			py_s2 <= PROD_W'(ky_s1) * PROD_W'(shift_y_q);
			px_s2 <= PROD_W'(kx_s1) * PROD_W'(shift_x_q);
			xg_s2 <= 64'(re_s1) * $signed({31'b0, INV_GAIN});
			yg_s2 <= 64'(im_s1) * $signed({31'b0, INV_GAIN});
		end
	end

	// ---- stage 3: dividend k*s*2^17 + n, folded to magnitude
	logic                 v_s3;
	logic signed [CW-1:0] x_s3, y_s3;
	logic                 negy_s3, negx_s3;
	logic [DIV_W-1:0]     uy_s3, ux_s3;
	logic [DIV_W-1:0]     dvy_c, dvx_c;

	always_comb begin
		dvy_c = DIV_W'(DIV_W'(py_s2) <<< 17) + DIV_W'(n_y);
		dvx_c = DIV_W'(DIV_W'(px_s2) <<< 17) + DIV_W'(n_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (ce)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// floor(D/d) of a negative D is ~floor(~D/d)
			negy_s3 <= dvy_c[DIV_W-1];
			negx_s3 <= dvx_c[DIV_W-1];
			uy_s3   <= dvy_c ^ {DIV_W{dvy_c[DIV_W-1]}};
			ux_s3   <= dvx_c ^ {DIV_W{dvx_c[DIV_W-1]}};
			x_s3    <= CW'(xg_s2 >>> 16);
			y_s3    <= CW'(yg_s2 >>> 16);
		end
	end

	// ---- divider stages
	logic                 v_sd   [0:DIV_STAGES];
	div_t                 dy_sd  [0:DIV_STAGES];
	div_t                 dx_sd  [0:DIV_STAGES];
	logic                 negy_sd[0:DIV_STAGES];
	logic                 negx_sd[0:DIV_STAGES];
	logic signed [CW-1:0] x_sd   [0:DIV_STAGES];
	logic signed [CW-1:0] y_sd   [0:DIV_STAGES];

	always_comb begin
		v_sd[0]    = v_s3;
		dy_sd[0]   = '{rem: '0, u: uy_s3, q: '0};
		dx_sd[0]   = '{rem: '0, u: ux_s3, q: '0};
		negy_sd[0] = negy_s3;
		negx_sd[0] = negx_s3;
		x_sd[0]    = x_s3;
		y_sd[0]    = y_s3;
	end

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sd[s+1] <= 1'b0;
			else if (ce)
				v_sd[s+1] <= v_sd[s];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				dy_sd[s+1]   <= div_steps(dy_sd[s], d_y);
				dx_sd[s+1]   <= div_steps(dx_sd[s], d_x);
				negy_sd[s+1] <= negy_sd[s];
				negx_sd[s+1] <= negx_sd[s];
				x_sd[s+1]    <= x_sd[s];
				y_sd[s+1]    <= y_sd[s];
			end
		end
	end

	// ---- phase, rounding to PHASE_BITS, quadrant fold
	logic               v_sp;
	cor_t               c_sp;
	logic [31:0]        ty_c, tx_c, ph_c, a_c;
	cor_t               c_c;

	always_comb begin
		ty_c = (n_y == '0) ? '0 :
			(negy_sd[DIV_STAGES] ? ~dy_sd[DIV_STAGES].q : dy_sd[DIV_STAGES].q);
		tx_c = (n_x == '0) ? '0 :
			(negx_sd[DIV_STAGES] ? ~dx_sd[DIV_STAGES].q : dx_sd[DIV_STAGES].q);
		ph_c = ((32'd0 - ty_c - tx_c) + PH_HALF) & PH_MASK;
		a_c  = ph_c + 32'h2000_0000;
		c_c.z = $signed({2'b00, a_c[29:0]}) - 32'sh2000_0000;
		case (a_c[31:30])
			2'd1: begin
				c_c.x = -y_sd[DIV_STAGES];
				c_c.y = x_sd[DIV_STAGES];
			end
			2'd2: begin
				c_c.x = -x_sd[DIV_STAGES];
				c_c.y = -y_sd[DIV_STAGES];
			end
			2'd3: begin
				c_c.x = y_sd[DIV_STAGES];
				c_c.y = -x_sd[DIV_STAGES];
			end
			default: begin
				c_c.x = x_sd[DIV_STAGES];
				c_c.y = y_sd[DIV_STAGES];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sp <= 1'b0;
		else if (ce)
			v_sp <= v_sd[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		if (ce)
			c_sp <= c_c;
	end

	// ---- CORDIC stages
	logic v_sc[0:COR_STAGES];
	cor_t c_sc[0:COR_STAGES];

	always_comb begin
		v_sc[0] = v_sp;
		c_sc[0] = c_sp;
	end

	for (genvar s = 0; s < COR_STAGES; s++) begin : g_cor
		cor_t nxt;

		always_comb begin
			nxt = c_sc[s];
			for (int m = 0; m < COR_PER; m++)
				nxt = cor_iter(nxt, s * COR_PER + m);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sc[s+1] <= 1'b0;
			else if (ce)
				v_sc[s+1] <= v_sc[s];
		end

		always_ff @(posedge clk) begin
			if (ce)
				c_sc[s+1] <= nxt;
		end
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ce)
			out_valid <= v_sc[COR_STAGES];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_data.shifted_real <= round_sat(c_sc[COR_STAGES].x);
			out_data.shifted_imag <= round_sat(c_sc[COR_STAGES].y);
		end
	end

`ifndef NO_ASSERTIONS
	// a held result freezes the CORDIC tail
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(v_sc[COR_STAGES]) && $stable(v_sp)))
		else $error("pipeline advanced while output held");

	// an input transfer lands in stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted coefficient lost at stage 1");

	// residual angle after quadrant fold stays within one eighth turn
	a_resid: assert property (@(posedge clk) disable iff (!arst_n)
		v_sp |-> (c_sp.z >= -32'sh2000_0000 && c_sp.z < 32'sh2000_0000))
		else $error("residual angle out of range");

	// input is only refused while a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input refused with free output");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fourier_phase_shift: directed coefficients, then
// random spectra over many register settings, checked against a bit-true
// phase-ramp and CORDIC predictor, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb
	import fps_pkg::*;
();

	localparam int LATENCY = 29;
	localparam int N_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	fps_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	fps_out_t    out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	fourier_phase_shift dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the register file
	logic [10:0] rows_reg;
	logic [9:0]  half_cols_reg;
	logic [31:0] shift_x_reg;
	logic [31:0] shift_y_reg;

	fps_out_t    pending_rot[$];
	int          n_errors;
	int          gap_mode;
	int          stall_mode;
	int          hold_seq;

	longint atan_lut [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	typedef struct {
		fps_in_t  stim;
		bit       typed;
		fps_out_t want;
	} dir_row_t;

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic [31:0] ramp_term(longint idx, longint n, longint s);
		longint k;
		longint q;
		if (n <= 0)
			return 32'd0;
		k = (idx <= n / 2) ? idx : idx - n;
		q = fdiv(k * s * 131072 + n, 2 * n);
		return q[31:0];
	endfunction

	function automatic logic [31:0] sat_round(longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic fps_out_t phase_rotate(fps_in_t d);
		longint   ny, nh, nx, x, y, t, z, dx, dy;
		logic [31:0] ph, a;
		logic [1:0]  quad;
		fps_out_t r;
		ny = (rows_reg > 11'd1024) ? 1024 : longint'(rows_reg);
		nh = (half_cols_reg > 10'd513) ? 513 : longint'(half_cols_reg);
		nx = (nh >= 2) ? 2 * (nh - 1) : 0;
		ph = 32'd0 - ramp_term(longint'(d.row_index), ny, longint'($signed(shift_y_reg)))
			- ramp_term(longint'(d.col_index), nx, longint'($signed(shift_x_reg)));
		ph = (ph + 32'd128) & 32'hFFFF_FF00;
		x = (longint'(d.sample_real) * 64'sd2608131496) >>> 16;
		y = (longint'(d.sample_imag) * 64'sd2608131496) >>> 16;
		a = ph + 32'h2000_0000;
		quad = a[31:30];
		z = longint'({2'b00, a[29:0]}) - 64'sd536870912;
		case (quad)
			2'd1: begin t = x; x = -y; y = t; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_lut[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_lut[i];
			end
		end
		r.shifted_real = sat_round(x);
		r.shifted_imag = sat_round(y);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("fourier_phase_shift: mismatch");
		$finish;
	end

	// directed row being offered, with its typed expectation
	logic     dir_active, dir_typed;
	fps_out_t dir_want;

	// sample both channels mid-cycle, act on the following edge
	logic     in_fire_s, out_fire_s;
	logic     in_typed_s;
	fps_out_t in_want_s;
	fps_in_t  in_d_s;
	fps_out_t out_d_s;
	always @(negedge clk) begin
		in_fire_s  <= in_valid && !in_stall;
		in_d_s     <= in_data;
		in_typed_s <= dir_active && dir_typed;
		in_want_s  <= dir_want;
		out_fire_s <= out_valid && !out_stall;
		out_d_s    <= out_data;
	end

	always @(posedge clk) begin
		fps_out_t e;
		if (arst_n && in_fire_s)
			pending_rot.push_back(in_typed_s ? in_want_s : phase_rotate(in_d_s));
		if (arst_n && out_fire_s) begin
			if (pending_rot.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected transfer: %h", out_d_s);
			end else begin
				e = pending_rot.pop_front();
				if (e.shifted_real !== out_d_s.shifted_real ||
						e.shifted_imag !== out_d_s.shifted_imag) begin
					n_errors++;
					if (n_errors <= 10)
						$display("rotated value wrong: exp re=%0d im=%0d got re=%0d im=%0d",
							e.shifted_real, e.shifted_imag,
							out_d_s.shifted_real, out_d_s.shifted_imag);
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		int hold_cnt;
		int seen_seq;
		int r;
		if (hold_seq != seen_seq) begin
			seen_seq = hold_seq;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (stall_mode == 0) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			out_stall <= (r < 25) || (r >= 98);
		end
	end

	function automatic int pick_gap();
		int r;
		if (gap_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sender side; in_valid stays high across back-to-back transfers
	task automatic send_coef(fps_in_t d);
		logic stall_s;
		int   g;
		in_valid <= 1'b1;
		in_data  <= d;
		do begin
			@(negedge clk);
			stall_s = in_stall;
			@(posedge clk);
		end while (stall_s);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		// the last transfer is queued by the monitor on this same edge
		@(posedge clk);
		while (pending_rot.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_NUM_ROWS:      rows_reg      = v[10:0];
			CFG_NUM_HALF_COLS: half_cols_reg = v[9:0];
			CFG_SHIFT_X:       shift_x_reg   = v;
			CFG_SHIFT_Y:       shift_y_reg   = v;
		endcase
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $signed($urandom) >>> $urandom_range(1, 30);
		endcase
	endfunction

	function automatic logic [9:0] rand_index(int n);
		if (n > 0 && $urandom_range(0, 99) < 85)
			return 10'($urandom_range(0, (n > 1024 ? 1024 : n) - 1));
		return 10'($urandom);
	endfunction

	function automatic fps_in_t rand_coef();
		fps_in_t d;
		int nx;
		nx = (half_cols_reg >= 2) ? 2 * (int'(half_cols_reg) - 1) : 0;
		d.row_index   = rand_index(int'(rows_reg));
		d.col_index   = rand_index(nx);
		d.sample_real = rand_sample();
		d.sample_imag = rand_sample();
		return d;
	endfunction

	function automatic logic [31:0] rand_shift();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 64 * 65536)) - 32'd2097152;
			default: return $urandom;
		endcase
	endfunction

	dir_row_t dir_tab[$];

	initial begin
		fps_in_t  d;
		fps_out_t zero_out;
		logic [31:0] rv;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_stall  = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_NUM_ROWS;
		cfg_data   = '0;
		n_errors   = 0;
		gap_mode   = 0;
		stall_mode = 0;
		hold_seq   = 0;
		dir_active = 1'b0;
		dir_typed  = 1'b0;
		dir_want   = '0;
		rows_reg      = 11'd256;
		half_cols_reg = 10'd129;
		shift_x_reg   = '0;
		shift_y_reg   = '0;
		zero_out      = '0;

		// zero coefficients stay zero whatever the phase; the rest use the predictor
		dir_tab.push_back('{'{10'd0, 10'd0, 32'sd0, 32'sd0}, 1'b1, zero_out});
		dir_tab.push_back('{'{10'd1023, 10'd1023, 32'sd0, 32'sd0}, 1'b1, zero_out});
		dir_tab.push_back('{'{10'd0, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'd0, 10'd0, 32'h8000_0000, 32'h8000_0000}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'd128, 10'd128, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'd129, 10'd255, 32'sd1, -32'sd1}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'd255, 10'd256, 32'sd1000, 32'sd0}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'd1023, 10'd0, -32'sd1, 32'sd65536}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'h2AA, 10'h155, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, zero_out});
		dir_tab.push_back('{'{10'h155, 10'h2AA, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, zero_out});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_active = 1'b1;
		foreach (dir_tab[i]) begin
			dir_typed = dir_tab[i].typed;
			dir_want  = dir_tab[i].want;
			send_coef(dir_tab[i].stim);
		end
		wait_idle();
		dir_active = 1'b0;

		// same rows under extreme shifts and degenerate lengths
		write_reg(CFG_SHIFT_X, 32'h7FFF_FFFF);
		write_reg(CFG_SHIFT_Y, 32'h8000_0000);
		write_reg(CFG_NUM_ROWS, 11'd2047);
		write_reg(CFG_NUM_HALF_COLS, 10'd1);
		foreach (dir_tab[i])
			send_coef(dir_tab[i].stim);
		wait_idle();
		write_reg(CFG_NUM_ROWS, 11'd0);
		write_reg(CFG_NUM_HALF_COLS, 10'd1023);
		foreach (dir_tab[i])
			send_coef(dir_tab[i].stim);
		wait_idle();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin
					write_reg(CFG_NUM_ROWS, 11'd2);
					write_reg(CFG_NUM_HALF_COLS, 10'd2);
				end
				1: begin
					write_reg(CFG_NUM_ROWS, 11'd1024);
					write_reg(CFG_NUM_HALF_COLS, 10'd513);
				end
				2: begin
					write_reg(CFG_NUM_ROWS, 11'd1025);
					write_reg(CFG_NUM_HALF_COLS, 10'd514);
				end
				3: begin
					write_reg(CFG_NUM_ROWS, 11'd1);
					write_reg(CFG_NUM_HALF_COLS, 10'd0);
				end
				default: begin
					write_reg(CFG_NUM_ROWS, 11'($urandom_range(2, 1024)));
					write_reg(CFG_NUM_HALF_COLS, 10'($urandom_range(2, 513)));
				end
			endcase
			rv = rand_shift();
			write_reg(CFG_SHIFT_X, rv);
			rv = rand_shift();
			write_reg(CFG_SHIFT_Y, rv);
			gap_mode   = (p % 3 == 2) ? 0 : 1;
			stall_mode = (p % 4 == 1) ? 0 : 1;
			if (p == 5) begin
				gap_mode = 0;
				hold_seq++;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				d = rand_coef();
				send_coef(d);
			end
			wait_idle();
		end

		if (n_errors == 0)
			$display("fourier_phase_shift: match");
		else
			$display("fourier_phase_shift: mismatch");
		$finish;
	end

endmodule
